@@ sv/aacd_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and types for the ambient average block.
package aacd_pkg;

    localparam int TEMP_W = 11;
    localparam int HUM_W  = 10;
    localparam int LUX_W  = 16;

    localparam int TTHR_W = 11;
    localparam int HTHR_W = 10;
    localparam int LTHR_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LUX_THR  = 2'd2;

    localparam logic [TTHR_W-1:0] TEMP_THR_RESET = 11'd5;
    localparam logic [HTHR_W-1:0] HUM_THR_RESET  = 10'd50;
    localparam logic [LTHR_W-1:0] LUX_THR_RESET  = 16'd10;

    localparam int WINDOW_LENGTH_DEFAULT = 5;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
        logic [LUX_W-1:0]         lux;
    } sample_t;

    typedef struct packed {
        logic load;
        logic prime;
    } cell_ctrl_t;

endpackage

@@ sv/aacd_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: sample input, result output and configuration write.
interface aacd_sample_if;
    import aacd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_reading;
    logic [HUM_W-1:0]         humidity_reading;
    logic [LUX_W-1:0]         illuminance_reading;

    modport source (output valid, output temperature_reading, output humidity_reading,
                    output illuminance_reading, input ready);
    modport sink   (input valid, input temperature_reading, input humidity_reading,
                    input illuminance_reading, output ready);
endinterface

interface aacd_result_if;
    import aacd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_average;
    logic [HUM_W-1:0]         humidity_average;
    logic [LUX_W-1:0]         illuminance_average;
    logic                     changed;

    modport source (output valid, output temperature_average, output humidity_average,
                    output illuminance_average, output changed, input ready);
    modport sink   (input valid, input temperature_average, input humidity_average,
                    input illuminance_average, input changed, output ready);
endinterface

interface aacd_cfg_if;
    import aacd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/aacd_cell.sv @@
`timescale 1ns / 1ps
// One window cell: holds a sample set and passes it to the next cell on each transfer.
module aacd_cell (
    input  logic                clk,
    input  aacd_pkg::cell_ctrl_t ctrl,
    input  aacd_pkg::sample_t   fresh,
    input  aacd_pkg::sample_t   prev,
    output aacd_pkg::sample_t   q
);
    import aacd_pkg::*;

    sample_t q_reg;

    // priming fills every cell with the fresh sample
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            q_reg <= ctrl.prime ? fresh : prev;
        end
    end

    assign q = q_reg;

endmodule

@@ sv/aacd_rdiv.sv @@
`timescale 1ns / 1ps
// Rounded divide by the window length: reciprocal multiply on a biased magnitude, then sign.
module aacd_rdiv #(
    parameter int WINDOW_LENGTH = aacd_pkg::WINDOW_LENGTH_DEFAULT,
    parameter int X_W           = 21,
    parameter int OUT_W         = 16
) (
    input  logic [X_W-1:0]   x,
    input  logic             neg,
    output logic [OUT_W-1:0] avg
);
    import aacd_pkg::*;

    localparam int LW    = $clog2(WINDOW_LENGTH);
    localparam int SHIFT = X_W + LW;
    localparam int M_W   = X_W + 2;
    localparam int P_W   = X_W + M_W;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

    logic [P_W-1:0]   prod;
    logic [OUT_W-1:0] quo;

    assign prod = P_W'(x) * P_W'(RECIP);
    assign quo  = prod[SHIFT +: OUT_W];
    assign avg  = neg ? OUT_W'(-quo) : quo;

endmodule

@@ sv/ambient_average_change_detect.sv @@
`timescale 1ns / 1ps
// Top level: window cell row, running sums, change detection and averaging pipeline.
//
//  channel   dir   handshake      payload
//  samples   in    valid/ready    temperature_reading, humidity_reading, illuminance_reading
//  results   out   valid/ready    temperature_average, humidity_average, illuminance_average,
//                                 changed
//  cfg       in    valid/ready    index, data (threshold write, ready always high)
//
// One sample set per cycle while results are taken; each result passes the stage 1, stage 2 and output registers.
// Stages: running-sum update, threshold compare with reported-sum update, reciprocal divide.
// Every stage advances independently, so bubbles close up while results are stalled.
// Reset clears sums, reported sums, the primed flag and stage valids; thresholds go to
// their default values. The first sample after reset fills the whole window.
module ambient_average_change_detect #(
    parameter int WINDOW_LENGTH = aacd_pkg::WINDOW_LENGTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    aacd_sample_if.sink samples,
    aacd_result_if.source results,
    aacd_cfg_if.sink    cfg
);
    import aacd_pkg::*;

    localparam int LW     = $clog2(WINDOW_LENGTH);
    localparam int TSUM_W = TEMP_W + LW;
    localparam int HSUM_W = HUM_W + LW;
    localparam int LSUM_W = LUX_W + LW;
    localparam int TX_W   = TSUM_W + 1;
    localparam int HX_W   = HSUM_W + 1;
    localparam int LX_W   = LSUM_W + 1;
    localparam int HALF   = WINDOW_LENGTH / 2;

    // config
    logic [TTHR_W-1:0] tthr_reg;
    logic [HTHR_W-1:0] hthr_reg;
    logic [LTHR_W-1:0] lthr_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tthr_reg <= TEMP_THR_RESET;
            hthr_reg <= HUM_THR_RESET;
            lthr_reg <= LUX_THR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TEMP_THR: tthr_reg <= cfg.data[TTHR_W-1:0];
                REG_HUM_THR:  hthr_reg <= cfg.data[HTHR_W-1:0];
                REG_LUX_THR:  lthr_reg <= cfg.data[LTHR_W-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic rdy1, rdy2, rdy3;
    logic fire;

    assign rdy3          = !s3_valid_reg || results.ready;
    assign rdy2          = !s2_valid_reg || rdy3;
    assign rdy1          = !s1_valid_reg || rdy2;
    assign samples.ready = rdy1;
    assign fire          = samples.valid && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= samples.valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // window cell row; last cell holds the oldest sample set
    sample_t    fresh;
    sample_t    cell_q [WINDOW_LENGTH];
    cell_ctrl_t cell_ctrl;
    logic       primed_reg;

    assign fresh.temp      = samples.temperature_reading;
    assign fresh.hum       = samples.humidity_reading;
    assign fresh.lux       = samples.illuminance_reading;
    assign cell_ctrl.load  = fire;
    assign cell_ctrl.prime = !primed_reg;

    for (genvar i = 0; i < WINDOW_LENGTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            aacd_cell u_cell (
                .clk   (clk),
                .ctrl  (cell_ctrl),
                .fresh (fresh),
                .prev  (fresh),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_body
            aacd_cell u_cell (
                .clk   (clk),
                .ctrl  (cell_ctrl),
                .fresh (fresh),
                .prev  (cell_q[i-1]),
                .q     (cell_q[i])
            );
        end
    end

    // stage 1: running sums
    logic signed [TSUM_W-1:0] tsum_reg, tsum_next;
    logic [HSUM_W-1:0]        hsum_reg, hsum_next;
    logic [LSUM_W-1:0]        lsum_reg, lsum_next;
    logic                     s1_prime_reg;
    sample_t                  oldest;

    assign oldest = cell_q[WINDOW_LENGTH-1];

    always_comb
    begin
        if (!primed_reg)
        begin
            tsum_next = TSUM_W'(fresh.temp * TSUM_W'(WINDOW_LENGTH));
            hsum_next = HSUM_W'(HSUM_W'(fresh.hum) * HSUM_W'(WINDOW_LENGTH));
            lsum_next = LSUM_W'(LSUM_W'(fresh.lux) * LSUM_W'(WINDOW_LENGTH));
        end
        else
        begin
            tsum_next = tsum_reg + TSUM_W'(fresh.temp) - TSUM_W'(oldest.temp);
            hsum_next = hsum_reg + HSUM_W'(fresh.hum) - HSUM_W'(oldest.hum);
            lsum_next = lsum_reg + LSUM_W'(fresh.lux) - LSUM_W'(oldest.lux);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            tsum_reg   <= '0;
            hsum_reg   <= '0;
            lsum_reg   <= '0;
        end
        else if (fire)
        begin
            primed_reg <= 1'b1;
            tsum_reg   <= tsum_next;
            hsum_reg   <= hsum_next;
            lsum_reg   <= lsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_prime_reg <= !primed_reg;
        end
    end

    // stage 2: compare against reported sums
    logic signed [TSUM_W-1:0] rep_tsum_reg;
    logic [HSUM_W-1:0]        rep_hsum_reg;
    logic [LSUM_W-1:0]        rep_lsum_reg;

    logic signed [TX_W-1:0] tdiff;
    logic signed [HX_W-1:0] hdiff;
    logic signed [LX_W-1:0] ldiff;
    logic [TX_W-1:0]        tdist;
    logic [HX_W-1:0]        hdist;
    logic [LX_W-1:0]        ldist;
    logic [TTHR_W+LW-1:0]   tlim;
    logic [HTHR_W+LW-1:0]   hlim;
    logic [LTHR_W+LW-1:0]   llim;
    logic                   changed_next;
    logic [TSUM_W-1:0]      tmag;
    logic                   load2;

    assign tdiff = TX_W'(tsum_reg) - TX_W'(rep_tsum_reg);
    assign hdiff = $signed({1'b0, hsum_reg}) - $signed({1'b0, rep_hsum_reg});
    assign ldiff = $signed({1'b0, lsum_reg}) - $signed({1'b0, rep_lsum_reg});
    assign tdist = tdiff[TX_W-1] ? TX_W'(-tdiff) : TX_W'(tdiff);
    assign hdist = hdiff[HX_W-1] ? HX_W'(-hdiff) : HX_W'(hdiff);
    assign ldist = ldiff[LX_W-1] ? LX_W'(-ldiff) : LX_W'(ldiff);
    assign tlim  = (TTHR_W+LW)'((TTHR_W+LW)'(tthr_reg) * (TTHR_W+LW)'(WINDOW_LENGTH));
    assign hlim  = (HTHR_W+LW)'((HTHR_W+LW)'(hthr_reg) * (HTHR_W+LW)'(WINDOW_LENGTH));
    assign llim  = (LTHR_W+LW)'((LTHR_W+LW)'(lthr_reg) * (LTHR_W+LW)'(WINDOW_LENGTH));

    assign changed_next = !s1_prime_reg &&
                          ((tdist > TX_W'(tlim)) ||
                           (hdist > HX_W'(hlim)) ||
                           (ldist > LX_W'(llim)));

    assign tmag  = tsum_reg[TSUM_W-1] ? TSUM_W'(-tsum_reg) : TSUM_W'(tsum_reg);
    assign load2 = rdy2 && s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_tsum_reg <= '0;
            rep_hsum_reg <= '0;
            rep_lsum_reg <= '0;
        end
        else if (load2 && changed_next)
        begin
            rep_tsum_reg <= tsum_reg;
            rep_hsum_reg <= hsum_reg;
            rep_lsum_reg <= lsum_reg;
        end
    end

    logic [TX_W-1:0] s2_tx_reg;
    logic            s2_tneg_reg;
    logic [HX_W-1:0] s2_hx_reg;
    logic [LX_W-1:0] s2_lx_reg;
    logic            s2_changed_reg;

    // biased magnitudes for round-half-away-from-zero
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_tx_reg      <= TX_W'(tmag) + TX_W'(HALF);
            s2_tneg_reg    <= tsum_reg[TSUM_W-1];
            s2_hx_reg      <= HX_W'(hsum_reg) + HX_W'(HALF);
            s2_lx_reg      <= LX_W'(lsum_reg) + LX_W'(HALF);
            s2_changed_reg <= changed_next;
        end
    end

    // stage 3: divide and output register
    logic [TEMP_W-1:0] tavg;
    logic [HUM_W-1:0]  havg;
    logic [LUX_W-1:0]  lavg;

    aacd_rdiv #(.WINDOW_LENGTH(WINDOW_LENGTH), .X_W(TX_W), .OUT_W(TEMP_W)) u_tdiv (
        .x   (s2_tx_reg),
        .neg (s2_tneg_reg),
        .avg (tavg)
    );

    aacd_rdiv #(.WINDOW_LENGTH(WINDOW_LENGTH), .X_W(HX_W), .OUT_W(HUM_W)) u_hdiv (
        .x   (s2_hx_reg),
        .neg (1'b0),
        .avg (havg)
    );

    aacd_rdiv #(.WINDOW_LENGTH(WINDOW_LENGTH), .X_W(LX_W), .OUT_W(LUX_W)) u_ldiv (
        .x   (s2_lx_reg),
        .neg (1'b0),
        .avg (lavg)
    );

    logic [TEMP_W-1:0] out_t_reg;
    logic [HUM_W-1:0]  out_h_reg;
    logic [LUX_W-1:0]  out_l_reg;
    logic              out_changed_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            out_t_reg       <= tavg;
            out_h_reg       <= havg;
            out_l_reg       <= lavg;
            out_changed_reg <= s2_changed_reg;
        end
    end

    assign results.valid               = s3_valid_reg;
    assign results.temperature_average = $signed(out_t_reg);
    assign results.humidity_average    = out_h_reg;
    assign results.illuminance_average = out_l_reg;
    assign results.changed             = out_changed_reg;

`ifndef SYNTH
    a_prime_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (load2 && s1_prime_reg) |=> !s2_changed_reg)
        else $error("priming sample flagged as changed");

    a_primed_set: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> primed_reg)
        else $error("primed flag not set after transfer");

    a_first_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !primed_reg) |=> s1_prime_reg)
        else $error("first sample not marked as priming");

    a_rep_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(rep_tsum_reg) || !$stable(rep_hsum_reg) || !$stable(rep_lsum_reg))
        |-> s2_changed_reg)
        else $error("reported sums moved without a change flag");
`endif

endmodule
